/* design/assert_macros.svh */
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while rst is high
`define ASSERT_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent on one edge requires consequent on the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/prba_pkg.sv */
// ----------------------------------------------------------------------------
// prba_pkg: shared constants for the point rotation block
// Angle formats, reduction thresholds, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
package prba_pkg;

   // input angle format
   localparam int ANGLE_WIDTH     = 18;
   localparam int ANGLE_FRAC_BITS = 8;

   // one full turn in input units, and the reduced angle width
   localparam int FULL_STEPS = 360 * 2**ANGLE_FRAC_BITS;
   localparam int MOD_WIDTH  = 17;
   localparam logic signed [ANGLE_WIDTH:0] FULL_TURN = (ANGLE_WIDTH+1)'(FULL_STEPS);
   localparam logic signed [ANGLE_WIDTH:0] TWO_TURNS = (ANGLE_WIDTH+1)'(2 * FULL_STEPS);

   // quadrant boundaries of the reduced angle, unsigned
   localparam logic [MOD_WIDTH-1:0] TURN_M         = MOD_WIDTH'(FULL_STEPS);
   localparam logic [MOD_WIDTH-1:0] QUARTER_M      = MOD_WIDTH'(FULL_STEPS / 4);
   localparam logic [MOD_WIDTH-1:0] HALF_M         = MOD_WIDTH'(FULL_STEPS / 2);
   localparam logic [MOD_WIDTH-1:0] THREE_QUART_M  = MOD_WIDTH'(3 * FULL_STEPS / 4);
   localparam logic [MOD_WIDTH-1:0] EIGHTH_M       = MOD_WIDTH'(FULL_STEPS / 8);
   localparam logic [MOD_WIDTH-1:0] THREE_EIGHTH_M = MOD_WIDTH'(3 * FULL_STEPS / 8);
   localparam logic [MOD_WIDTH-1:0] FIVE_EIGHTH_M  = MOD_WIDTH'(5 * FULL_STEPS / 8);
   localparam logic [MOD_WIDTH-1:0] SEVEN_EIGHTH_M = MOD_WIDTH'(7 * FULL_STEPS / 8);

   // residual magnitude, at most an eighth of a turn
   localparam int RESID_WIDTH = 14;

   // datapath: 24 fraction bits, extra bits over the coordinate width
   localparam int DP_FRAC  = 24;
   localparam int DP_EXTRA = 26;
   localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

   // angle accumulator in radians, 36 fraction bits
   localparam int Z_FRAC  = 36;
   localparam int Z_WIDTH = 38;
   localparam longint PI_Q36 = 64'h0000_0032_43F6_A888;

   // residual to radians: r * pi / (180 * 2^frac), 180 * 2^frac = 45 * 2^(frac+2)
   localparam int Z_DIV_ODD   = 45;
   localparam int Z_DIV_SHIFT = ANGLE_FRAC_BITS + 2;
   localparam longint Z_DIV   = longint'(Z_DIV_ODD) << Z_DIV_SHIFT;

   // pi split into quotient and remainder over the divisor
   localparam int Z_QUOT_WIDTH = 23;
   localparam int Z_REM_WIDTH  = 16;
   localparam logic [Z_QUOT_WIDTH-1:0] Z_QUOT = Z_QUOT_WIDTH'(PI_Q36 / Z_DIV);
   localparam logic [Z_REM_WIDTH-1:0]  Z_REM  = Z_REM_WIDTH'(PI_Q36 % Z_DIV);

   // reciprocal of the odd factor for the remainder quotient
   localparam int RECIP_WIDTH = 23;
   localparam int RECIP_SHIFT = 28;
   localparam logic [RECIP_WIDTH-1:0] RECIP_ODD =
      RECIP_WIDTH'((2**RECIP_SHIFT + Z_DIV_ODD - 1) / Z_DIV_ODD);

   // arctangent of 2^-idx in radians, rounded to the accumulator format
   function automatic logic [Z_WIDTH-1:0] atan_q36(input int unsigned idx);
      real ang;
      ang = $atan(2.0 ** (-1.0 * idx)) * (2.0 ** Z_FRAC);
      return Z_WIDTH'(longint'($floor(ang + 0.5)));
   endfunction

endpackage

/* design/prba_prep.sv */
// ----------------------------------------------------------------------------
// prba_prep: angle reduction and operand setup
// Five elastic stages: modulo a turn, quadrant swap, gain and angle products,
// remainder quotient, and the signed start angle for the rotation cells.
// ----------------------------------------------------------------------------
module prba_prep #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_take,
   input  logic signed [COORD_WIDTH-1:0]                    in_x,
   input  logic signed [COORD_WIDTH-1:0]                    in_y,
   input  logic signed [prba_pkg::ANGLE_WIDTH-1:0]          in_angle,
   output logic                                             out_valid,
   input  logic                                             out_take,
   output logic signed [COORD_WIDTH+prba_pkg::DP_EXTRA-1:0] out_x,
   output logic signed [COORD_WIDTH+prba_pkg::DP_EXTRA-1:0] out_y,
   output logic signed [prba_pkg::Z_WIDTH-1:0]              out_z
);
   import prba_pkg::*;

   localparam int STAGES   = 5;
   localparam int DP_WIDTH = COORD_WIDTH + DP_EXTRA;
   localparam int PROD_W   = COORD_WIDTH + 34;
   localparam int ZS_W     = RESID_WIDTH + Z_REM_WIDTH;
   localparam int ZV_W     = ZS_W - Z_DIV_SHIFT;
   localparam int ZF_W     = ZV_W + RECIP_WIDTH - RECIP_SHIFT;

   typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_type;

   // elastic control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   take;

   always_comb begin
      take[STAGES] = out_take;
      for (int k = STAGES - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
      valid_in[0] = take[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = take[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_take   = take[0];
   assign out_valid = valid_ff[STAGES-1];

   // stage 1: angle modulo a full turn
   logic signed [ANGLE_WIDTH:0]   a_ext;
   logic signed [ANGLE_WIDTH:0]   m_sum;
   logic [MOD_WIDTH-1:0]          m1_ff;
   logic signed [COORD_WIDTH-1:0] px1_ff, py1_ff;

   always_comb begin
      a_ext = {in_angle[ANGLE_WIDTH-1], in_angle};
      if (a_ext < -FULL_TURN) begin
         m_sum = a_ext + TWO_TURNS;
      end else if (a_ext < 0) begin
         m_sum = a_ext + FULL_TURN;
      end else if (a_ext >= FULL_TURN) begin
         m_sum = a_ext - FULL_TURN;
      end else begin
         m_sum = a_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         m1_ff  <= m_sum[MOD_WIDTH-1:0];
         px1_ff <= in_x;
         py1_ff <= in_y;
      end
   end

   // stage 2: nearest quadrant, exact swap and negation, residual
   quadrant_type                  quad;
   logic [MOD_WIDTH-1:0]          base;
   logic signed [MOD_WIDTH:0]     resid;
   logic signed [COORD_WIDTH:0]   px_w, py_w, qx, qy;
   logic signed [COORD_WIDTH:0]   x2_ff, y2_ff;
   logic [RESID_WIDTH-1:0]        rmag2_ff;
   logic                          rneg2_ff;

   always_comb begin
      if (m1_ff >= SEVEN_EIGHTH_M) begin
         quad = QUAD_0;
         base = TURN_M;
      end else if (m1_ff >= FIVE_EIGHTH_M) begin
         quad = QUAD_270;
         base = THREE_QUART_M;
      end else if (m1_ff >= THREE_EIGHTH_M) begin
         quad = QUAD_180;
         base = HALF_M;
      end else if (m1_ff >= EIGHTH_M) begin
         quad = QUAD_90;
         base = QUARTER_M;
      end else begin
         quad = QUAD_0;
         base = '0;
      end
      resid = $signed({1'b0, m1_ff}) - $signed({1'b0, base});
      px_w  = {px1_ff[COORD_WIDTH-1], px1_ff};
      py_w  = {py1_ff[COORD_WIDTH-1], py1_ff};
      case (quad)
         QUAD_90: begin
            qx = -py_w;
            qy = px_w;
         end
         QUAD_180: begin
            qx = -px_w;
            qy = -py_w;
         end
         QUAD_270: begin
            qx = py_w;
            qy = -px_w;
         end
         default: begin
            qx = px_w;
            qy = py_w;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (take[1]) begin
         x2_ff    <= qx;
         y2_ff    <= qy;
         rneg2_ff <= resid[MOD_WIDTH];
         rmag2_ff <= resid[MOD_WIDTH] ? RESID_WIDTH'(-resid) : RESID_WIDTH'(resid);
      end
   end

   // stage 3: gain compensation and angle products
   logic signed [PROD_W-1:0]        gx_prod, gy_prod;
   logic signed [DP_WIDTH-1:0]      gx3_ff, gy3_ff;
   logic [Z_WIDTH-2:0]              zq3_ff;
   logic [ZS_W-1:0]                 zs3_ff;
   logic                            rneg3_ff;

   assign gx_prod = x2_ff * $signed({1'b0, GAIN_Q32});
   assign gy_prod = y2_ff * $signed({1'b0, GAIN_Q32});

   always_ff @(posedge clock) begin
      if (take[2]) begin
         // arithmetic shift by 8 rounds toward minus infinity
         gx3_ff   <= gx_prod[PROD_W-1:8];
         gy3_ff   <= gy_prod[PROD_W-1:8];
         zq3_ff   <= (Z_WIDTH-1)'(rmag2_ff) * Z_QUOT;
         zs3_ff   <= ZS_W'(rmag2_ff) * Z_REM;
         rneg3_ff <= rneg2_ff;
      end
   end

   // stage 4: remainder part divided by the odd factor through a reciprocal
   logic [ZV_W-1:0]                 zv;
   logic [ZV_W+RECIP_WIDTH-1:0]     zf_prod;
   logic signed [DP_WIDTH-1:0]      gx4_ff, gy4_ff;
   logic [Z_WIDTH-2:0]              zq4_ff;
   logic [ZF_W-1:0]                 zf4_ff;
   logic                            rneg4_ff;

   assign zv      = zs3_ff[ZS_W-1:Z_DIV_SHIFT];
   assign zf_prod = zv * RECIP_ODD;

   always_ff @(posedge clock) begin
      if (take[3]) begin
         gx4_ff   <= gx3_ff;
         gy4_ff   <= gy3_ff;
         zq4_ff   <= zq3_ff;
         zf4_ff   <= zf_prod[RECIP_SHIFT +: ZF_W];
         rneg4_ff <= rneg3_ff;
      end
   end

   // stage 5: signed start angle, truncated toward zero
   logic [Z_WIDTH-2:0]              zmag;
   logic signed [Z_WIDTH-1:0]       z_pos;
   logic signed [DP_WIDTH-1:0]      gx5_ff, gy5_ff;
   logic signed [Z_WIDTH-1:0]       z5_ff;

   assign zmag  = zq4_ff + (Z_WIDTH-1)'(zf4_ff);
   assign z_pos = $signed({1'b0, zmag});

   always_ff @(posedge clock) begin
      if (take[4]) begin
         gx5_ff <= gx4_ff;
         gy5_ff <= gy4_ff;
         z5_ff  <= rneg4_ff ? -z_pos : z_pos;
      end
   end

   assign out_x = gx5_ff;
   assign out_y = gy5_ff;
   assign out_z = z5_ff;

endmodule

/* design/prba_cell.sv */
// ----------------------------------------------------------------------------
// prba_cell: one CORDIC micro-rotation
// Holds one item, rotates by plus or minus atan(2^-STAGE) and hands it on.
// ----------------------------------------------------------------------------
module prba_cell #(
   parameter int DP_WIDTH = 42,
   parameter int STAGE    = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_take,
   input  logic signed [DP_WIDTH-1:0]         in_x,
   input  logic signed [DP_WIDTH-1:0]         in_y,
   input  logic signed [prba_pkg::Z_WIDTH-1:0] in_z,
   output logic                               out_valid,
   input  logic                               out_take,
   output logic signed [DP_WIDTH-1:0]         out_x,
   output logic signed [DP_WIDTH-1:0]         out_y,
   output logic signed [prba_pkg::Z_WIDTH-1:0] out_z
);
   import prba_pkg::*;

   localparam logic signed [Z_WIDTH-1:0] ATAN_STEP = atan_q36(STAGE);

   logic                       valid_ff, valid_in;
   logic signed [DP_WIDTH-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [Z_WIDTH-1:0]  z_ff, z_in;

   // cell is free when empty or when its content moves on
   assign in_take  = !valid_ff || out_take;
   assign valid_in = in_take ? in_valid : valid_ff;

   // micro-rotation, shifts round toward minus infinity
   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (!in_z[Z_WIDTH-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN_STEP;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_take) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

/* design/point_rotation_by_angle.sv */
// An item passes the prep stages, the rotation cells and the output register in turn.
// Throughput: one point per cycle unless stalled; every stage is an elastic register,
// and the CORDIC_STEPS rotation cells plus the output register carry one item each.
// A stalled result stops only the stages behind it that are full.
// Reset clears all valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// point_rotation_by_angle: rotate an integer point by an angle in degrees
// Quadrant reduction, gain-compensated CORDIC chain, truncation toward zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_rotation_by_angle #(
   parameter int COORD_WIDTH  = 16,
   parameter int CORDIC_STEPS = 20
) (
   input  logic clock,
   input  logic reset,
   // point_x, point_y, angle_deg, zero fill
   input  logic [8*((2*COORD_WIDTH+prba_pkg::ANGLE_WIDTH+7)/8)-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // rotated_x, rotated_y, zero fill
   output logic [8*((2*(COORD_WIDTH+1)+7)/8)-1:0]                  rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready
);
   import prba_pkg::*;

   localparam int DP_WIDTH = COORD_WIDTH + DP_EXTRA;
   localparam int OUT_W    = COORD_WIDTH + 1;
   localparam int RSP_W    = 8 * ((2 * OUT_W + 7) / 8);
   localparam logic signed [Z_WIDTH-1:0] Z_LIMIT = Z_WIDTH'(PI_Q36 / 4 + 1);

   // chain links between prep, cells and output register
   logic                       chain_valid [0:CORDIC_STEPS];
   logic                       chain_take  [0:CORDIC_STEPS];
   logic signed [DP_WIDTH-1:0] chain_x     [0:CORDIC_STEPS];
   logic signed [DP_WIDTH-1:0] chain_y     [0:CORDIC_STEPS];
   logic signed [Z_WIDTH-1:0]  chain_z     [0:CORDIC_STEPS];

   // angle reduction and operand setup
   prba_prep #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_take   (req_tready),
      .in_x      (req_tdata[COORD_WIDTH-1:0]),
      .in_y      (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .in_angle  (req_tdata[2*COORD_WIDTH +: ANGLE_WIDTH]),
      .out_valid (chain_valid[0]),
      .out_take  (chain_take[0]),
      .out_x     (chain_x[0]),
      .out_y     (chain_y[0]),
      .out_z     (chain_z[0])
   );

   // rotation cells
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      prba_cell #(
         .DP_WIDTH (DP_WIDTH),
         .STAGE    (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_take   (chain_take[i]),
         .in_x      (chain_x[i]),
         .in_y      (chain_y[i]),
         .in_z      (chain_z[i]),
         .out_valid (chain_valid[i+1]),
         .out_take  (chain_take[i+1]),
         .out_x     (chain_x[i+1]),
         .out_y     (chain_y[i+1]),
         .out_z     (chain_z[i+1])
      );
   end

   // truncation toward zero: bias negative values before the shift
   logic signed [DP_WIDTH-1:0] bias_x, bias_y, tx, ty;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]           rx_ff, ry_ff;

   assign bias_x = $signed({{(DP_WIDTH-DP_FRAC){1'b0}}, {DP_FRAC{chain_x[CORDIC_STEPS][DP_WIDTH-1]}}});
   assign bias_y = $signed({{(DP_WIDTH-DP_FRAC){1'b0}}, {DP_FRAC{chain_y[CORDIC_STEPS][DP_WIDTH-1]}}});
   assign tx     = chain_x[CORDIC_STEPS] + bias_x;
   assign ty     = chain_y[CORDIC_STEPS] + bias_y;

   // output register, refilled whenever empty or its transfer completes
   assign chain_take[CORDIC_STEPS] = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = chain_take[CORDIC_STEPS] ? chain_valid[CORDIC_STEPS] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (chain_take[CORDIC_STEPS]) begin
         rx_ff <= tx[DP_FRAC +: OUT_W];
         ry_ff <= ty[DP_FRAC +: OUT_W];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-2*OUT_W){1'b0}}, ry_ff, rx_ff};

   // checks
   `ASSERT_CHECK(a_stall_only_from_output, clock, reset, !req_tready |-> (rsp_tvalid && !rsp_tready), "input stalled while output register free")
   `ASSERT_NEXT(a_output_fills, clock, reset, chain_valid[CORDIC_STEPS] && !rsp_valid_ff, rsp_valid_ff, "finished item not moved into output register")
   `ASSERT_CHECK(a_start_angle_range, clock, reset, chain_valid[0] |-> (chain_z[0] <= Z_LIMIT && chain_z[0] >= -Z_LIMIT), "start angle outside plus or minus 45 degrees")
   `ASSERT_NEXT(a_reset_clears_output, clock, 1'b0, reset, !rsp_tvalid, "result valid right after reset")

endmodule
